/* src/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, codes and the CRC-16 byte step of the Modbus RTU response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int MAX_FRAME_DEFAULT = 256;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam int EXP_LEN_W = 9;
    localparam int KIND_W    = 2;
    localparam int RCRC_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [EXP_LEN_W-1:0] EXP_LEN_RESET = 9'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_LENGTH = 2'd0,
        CFG_COMMAND_KIND    = 2'd1,
        CFG_REQUEST_CRC     = 2'd2
    } cfg_index_t;

    typedef enum logic [KIND_W-1:0] {
        CMD_WRITE_SINGLE = 2'd0,
        CMD_WRITE_MULTI  = 2'd1,
        CMD_READ_MULTI   = 2'd2,
        CMD_OTHER        = 2'd3
    } command_kind_t;

    typedef enum logic [2:0] {
        VERDICT_LEN_ERR    = 3'd0,
        VERDICT_WRITE_OK   = 3'd1,
        VERDICT_MULTI_OK   = 3'd2,
        VERDICT_READ_OK    = 3'd3,
        VERDICT_CRC_ERR    = 3'd4
    } verdict_t;

    // Summary of one finished frame, handed from the front end to the checker.
    typedef struct packed {
        logic        len_ok;
        logic        short_frame;
        logic [7:0]  held_lo;
        logic [7:0]  held_hi;
        logic [15:0] crc;
    } frame_rec_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* src/mrc_ifs.sv */
// ----------------------------------------------------------------------------
// mrc_ifs
// Valid/ready channels for received bytes and for frame verdicts.
// ----------------------------------------------------------------------------
interface mrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrc_verdict_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [15:0] computed_crc;

    modport source (output valid, output verdict, output computed_crc, input ready);
    modport sink (input valid, input verdict, input computed_crc, output ready);
endinterface

/* src/mrc_front.sv */
// ----------------------------------------------------------------------------
// mrc_front
// Accepts response bytes, keeps the running CRC, byte count and two held bytes,
// and pushes a frame summary into the queue on the last byte.
// ----------------------------------------------------------------------------
module mrc_front #(
    parameter int MAX_FRAME = mrc_pkg::MAX_FRAME_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mrc_byte_if.sink                        rx,
    input  logic [mrc_pkg::EXP_LEN_W-1:0]   expected_length,
    input  logic                            q_full,
    output logic                            q_push,
    output mrc_pkg::frame_rec_t             q_data
);

    localparam int CW   = $clog2(MAX_FRAME + 2);
    localparam int CMPW = (CW > mrc_pkg::EXP_LEN_W) ? CW : mrc_pkg::EXP_LEN_W;

    logic [15:0]   crc_reg, crc_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    held0_reg, held0_next;
    logic [7:0]    held1_reg, held1_next;
    logic [15:0]   crc_step;
    logic [CW-1:0] count_step;
    logic          accept;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        crc_step   = (count_reg >= CW'(2)) ? mrc_pkg::crc_fold(crc_reg, held0_reg) : crc_reg;
        count_step = (count_reg < CW'(MAX_FRAME + 1)) ? count_reg + CW'(1) : count_reg;

        q_push              = accept && rx.frame_end;
        q_data.len_ok       = (count_step <= CW'(MAX_FRAME))
                              && (CMPW'(count_step) == CMPW'(expected_length));
        q_data.short_frame  = count_step < CW'(2);
        q_data.held_lo      = held1_reg;
        q_data.held_hi      = rx.rx_byte;
        q_data.crc          = crc_step;

        crc_next   = crc_reg;
        count_next = count_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        if (accept)
        begin
            if (rx.frame_end)
            begin
                crc_next   = mrc_pkg::CRC_INIT;
                count_next = '0;
                held0_next = '0;
                held1_next = '0;
            end
            else
            begin
                crc_next   = crc_step;
                count_next = count_step;
                held0_next = held1_reg;
                held1_next = rx.rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= mrc_pkg::CRC_INIT;
            count_reg <= '0;
            held0_reg <= '0;
            held1_reg <= '0;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

/* src/mrc_queue.sv */
// ----------------------------------------------------------------------------
// mrc_queue
// Two-entry queue of frame summaries between the front end and the checker.
// ----------------------------------------------------------------------------
module mrc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mrc_pkg::frame_rec_t  push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 empty,
    output mrc_pkg::frame_rec_t  head
);

    mrc_pkg::frame_rec_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full  = fill_reg == 2'd2;
    assign empty = fill_reg == 2'd0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

/* src/mrc_back.sv */
// ----------------------------------------------------------------------------
// mrc_back
// Takes frame summaries from the queue, decides the verdict for the pending
// command kind and holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module mrc_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  mrc_pkg::frame_rec_t            q_head,
    output logic                           q_pop,
    input  logic [mrc_pkg::KIND_W-1:0]     command_kind,
    input  logic [mrc_pkg::RCRC_W-1:0]     request_crc,
    mrc_verdict_if.source                  tx
);

    logic              valid_reg, valid_next;
    mrc_pkg::verdict_t verdict_reg, verdict_calc;
    logic [15:0]       crc_reg;
    logic              echo_ok;
    logic              crc_ok;

    assign q_pop = !q_empty && (!valid_reg || tx.ready);

    always_comb
    begin
        echo_ok = (q_head.held_lo == request_crc[7:0]) && (q_head.held_hi == request_crc[15:8]);
        crc_ok  = (q_head.held_lo == q_head.crc[7:0]) && (q_head.held_hi == q_head.crc[15:8]);
        if (!q_head.len_ok)
        begin
            verdict_calc = mrc_pkg::VERDICT_LEN_ERR;
        end
        else if (q_head.short_frame)
        begin
            verdict_calc = mrc_pkg::VERDICT_CRC_ERR;
        end
        else
        begin
            case (command_kind)
                mrc_pkg::CMD_WRITE_SINGLE:
                    verdict_calc = echo_ok ? mrc_pkg::VERDICT_WRITE_OK
                                           : mrc_pkg::VERDICT_CRC_ERR;
                mrc_pkg::CMD_WRITE_MULTI:
                    verdict_calc = crc_ok ? mrc_pkg::VERDICT_MULTI_OK
                                          : mrc_pkg::VERDICT_CRC_ERR;
                mrc_pkg::CMD_READ_MULTI:
                    verdict_calc = crc_ok ? mrc_pkg::VERDICT_READ_OK
                                          : mrc_pkg::VERDICT_CRC_ERR;
                default:
                    verdict_calc = mrc_pkg::VERDICT_CRC_ERR;
            endcase
        end

        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            verdict_reg <= verdict_calc;
            crc_reg     <= q_head.crc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign tx.valid        = valid_reg;
    assign tx.verdict      = verdict_reg;
    assign tx.computed_crc = crc_reg;

endmodule

/* src/modbus_rtu_response_checker.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Checks Modbus RTU response frames byte by byte and reports one verdict per frame.
// ----------------------------------------------------------------------------
// Usage:
// Response bytes arrive on the rx channel, one request per byte, with frame_end
// set on the last byte of a frame. Each finished frame yields one request on
// the result channel carrying the verdict and the CRC-16 over all bytes but
// the last two. Bytes without frame_end yield nothing.
// The byte channel takes one byte per cycle while the queue is not full; the CRC step is one byte wide.
// The last byte of a frame writes a queue entry, which moves in turn into the
// output register once that register is empty or its verdict is being taken.
// A two-entry queue separates the byte front end from the verdict stage, so up
// to two finished frames plus one held result can wait on a stalled receiver;
// only then is rx.ready dropped.
// The three configuration registers are written through cfg_write_en,
// cfg_index and cfg_data, and must only change while no frame is in flight.
// Reset clears the frame state (CRC to 0xFFFF, count and held bytes to zero),
// empties the queue and sets expected_length to 8, the other registers to 0.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker #(
    parameter int MAX_FRAME = mrc_pkg::MAX_FRAME_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [mrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrc_pkg::CFG_DATA_W-1:0]    cfg_data,
    mrc_byte_if.sink                          rx,
    mrc_verdict_if.source                     result
);

    logic [mrc_pkg::EXP_LEN_W-1:0] expected_length_reg;
    logic [mrc_pkg::KIND_W-1:0]    command_kind_reg;
    logic [mrc_pkg::RCRC_W-1:0]    request_crc_reg;

    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    mrc_pkg::frame_rec_t q_in;
    mrc_pkg::frame_rec_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_length_reg <= mrc_pkg::EXP_LEN_RESET;
            command_kind_reg    <= mrc_pkg::CMD_WRITE_SINGLE;
            request_crc_reg     <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                mrc_pkg::CFG_EXPECTED_LENGTH:
                    expected_length_reg <= cfg_data[mrc_pkg::EXP_LEN_W-1:0];
                mrc_pkg::CFG_COMMAND_KIND:
                    command_kind_reg <= cfg_data[mrc_pkg::KIND_W-1:0];
                mrc_pkg::CFG_REQUEST_CRC:
                    request_crc_reg <= cfg_data[mrc_pkg::RCRC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mrc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx              (rx),
        .expected_length (expected_length_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (q_in)
    );

    mrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    mrc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .command_kind (command_kind_reg),
        .request_crc  (request_crc_reg),
        .tx           (result)
    );

endmodule

/* tb/modbus_rtu_response_checker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_tb
// Drives Modbus RTU response frames into the checker one byte at a time and
// compares every verdict and computed CRC with a cycle-free model of the
// frame checks. Register settings change between phases while the block is
// idle. The byte source idles in bursts and the verdict sink runs free, stalls
// at random or stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_tb;

    import mrc_pkg::*;

    localparam int FRAME_LIMIT   = MAX_FRAME_DEFAULT;
    localparam int BYTE_BUDGET   = 1450;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LATENCY_SLACK = 6;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } stall_mode_t;

    typedef logic [7:0] frame_bytes_t[$];

    class verdict_scoreboard;
        typedef struct {
            verdict_t    verdict;
            logic [15:0] crc;
        } verdict_rec_t;

        logic [EXP_LEN_W-1:0] exp_len;
        command_kind_t        kind;
        logic [RCRC_W-1:0]    req_crc;

        logic [15:0] crc_acc;
        int unsigned count;
        logic [7:0]  held_old;
        logic [7:0]  held_new;

        verdict_rec_t expected_verdicts[$];
        int unsigned  mismatches;
        int unsigned  checked;
        int unsigned  seen[5];

        function new();
            exp_len = EXP_LEN_RESET;
            kind    = CMD_WRITE_SINGLE;
            req_crc = '0;
            mismatches = 0;
            checked    = 0;
            foreach (seen[i])
                seen[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            crc_acc  = CRC_INIT;
            count    = 0;
            held_old = '0;
            held_new = '0;
        endfunction

        static function logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] r;
            r = c;
            for (int i = 0; i < 8; i++)
            begin
                if (r[0] ^ b[i])
                    r = (r >> 1) ^ CRC_POLY;
                else
                    r = r >> 1;
            end
            return r;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_EXPECTED_LENGTH: exp_len = data[EXP_LEN_W-1:0];
                CFG_COMMAND_KIND:    kind = command_kind_t'(data[KIND_W-1:0]);
                CFG_REQUEST_CRC:     req_crc = data[RCRC_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_byte(input logic [7:0] b, input logic last);
            verdict_rec_t r;
            if (count >= 2)
                crc_acc = crc_byte(crc_acc, held_old);
            held_old = held_new;
            held_new = b;
            if (count < FRAME_LIMIT + 1)
                count++;
            if (!last)
                return;
            if (count > FRAME_LIMIT || count != exp_len)
                r.verdict = VERDICT_LEN_ERR;
            else if (count < 2)
                r.verdict = VERDICT_CRC_ERR;
            else
            begin
                case (kind)
                    CMD_WRITE_SINGLE:
                        r.verdict = ({held_new, held_old} == req_crc) ?
                                    VERDICT_WRITE_OK : VERDICT_CRC_ERR;
                    CMD_WRITE_MULTI:
                        r.verdict = ({held_new, held_old} == crc_acc) ?
                                    VERDICT_MULTI_OK : VERDICT_CRC_ERR;
                    CMD_READ_MULTI:
                        r.verdict = ({held_new, held_old} == crc_acc) ?
                                    VERDICT_READ_OK : VERDICT_CRC_ERR;
                    default:
                        r.verdict = VERDICT_CRC_ERR;
                endcase
            end
            r.crc = crc_acc;
            expected_verdicts.push_back(r);
            clear_frame();
        endfunction

        function void check_result(input logic [2:0] v, input logic [15:0] c);
            verdict_rec_t r;
            bit           bad;
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected verdict %0d crc %h with nothing pending",
                             $realtime, v, c);
                return;
            end
            r = expected_verdicts.pop_front();
            checked++;
            seen[int'(r.verdict)]++;
            bad = 1'b0;
            if (v !== r.verdict)
                bad = 1'b1;
            if (c !== r.crc)
                bad = 1'b1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: verdict expected %0d got %0d, crc expected %h got %h",
                             $realtime, r.verdict, v, r.crc, c);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mrc_byte_if    rx_if();
    mrc_verdict_if res_if();

    verdict_scoreboard sb;

    int unsigned bytes_sent;
    int unsigned frames_sent;
    int unsigned settings_used;
    int unsigned burst_left;
    bit          steady;
    int unsigned cycles;

    modbus_rtu_response_checker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx           (rx_if),
        .result       (res_if)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rx_if.valid === 1'b1 && rx_if.ready === 1'b1)
            sb.take_byte(rx_if.rx_byte, rx_if.frame_end);
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            sb.check_result(res_if.verdict, res_if.computed_crc);
    end

    initial
    begin
        stall_mode_t mode;
        logic [15:0] pattern;
        int unsigned left;
        res_if.ready = 1'b0;
        mode    = STALL_NONE;
        pattern = 16'hFFFF;
        left    = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                left    = $urandom_range(50, 300);
                mode    = stall_mode_t'($urandom_range(0, 2));
                pattern = 16'($urandom()) | 16'h0001;
            end
            left--;
            case (mode)
                STALL_NONE:   res_if.ready <= 1'b1;
                STALL_RANDOM: res_if.ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    res_if.ready <= pattern[0];
                    pattern = {pattern[0], pattern[15:1]};
                end
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        rx_if.valid     <= 1'b1;
        rx_if.rx_byte   <= b;
        rx_if.frame_end <= last;
        @(posedge clk);
        while (rx_if.ready !== 1'b1)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input frame_bytes_t f);
        for (int i = 0; i < f.size(); i++)
            send_byte(f[i], i == f.size() - 1);
        frames_sent++;
    endtask

    task automatic settle();
        rx_if.valid <= 1'b0;
        while (sb.expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (LATENCY_SLACK) @(negedge clk);
    endtask

    // Builds a frame whose tail is the check the current command kind expects, or
    // CRC or request CRC at random for CMD_OTHER, optionally one tail bit flipped.
    function automatic frame_bytes_t make_frame(input int len, input bit intact);
        frame_bytes_t f;
        logic [15:0]  c;
        logic [15:0]  tail;
        logic [7:0]   b;
        c = CRC_INIT;
        if (len < 2)
        begin
            for (int i = 0; i < len; i++)
                f.push_back(8'($urandom()));
            return f;
        end
        for (int i = 0; i < len - 2; i++)
        begin
            b = 8'($urandom());
            f.push_back(b);
            c = verdict_scoreboard::crc_byte(c, b);
        end
        case (sb.kind)
            CMD_WRITE_SINGLE: tail = sb.req_crc;
            CMD_WRITE_MULTI:  tail = c;
            CMD_READ_MULTI:   tail = c;
            default:          tail = $urandom_range(0, 1) ? c : sb.req_crc;
        endcase
        if (!intact)
            tail ^= 16'(1) << $urandom_range(0, 15);
        f.push_back(tail[7:0]);
        f.push_back(tail[15:8]);
        return f;
    endfunction

    initial
    begin
        frame_bytes_t f;
        int           e;
        int           len;
        int           r;
        int           n_frames;
        int           long_frames;
        int           full_phases;

        rst_n           = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rx_if.valid     = 1'b0;
        rx_if.rx_byte   = '0;
        rx_if.frame_end = 1'b0;
        sb            = new();
        bytes_sent    = 0;
        frames_sent   = 0;
        settings_used = 1;
        burst_left    = 0;
        steady        = 1'b0;
        cycles        = 0;
        long_frames   = 0;
        full_phases   = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The reset settings expect an eight-byte write echo of a zero CRC.
        f = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};
        send_frame(f);
        settle();

        write_reg(CFG_EXPECTED_LENGTH, 16'd1);
        write_reg(CFG_COMMAND_KIND, 16'(CMD_WRITE_MULTI));
        write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
        settings_used++;
        f = '{8'hFF};
        send_frame(f);
        settle();

        write_reg(CFG_EXPECTED_LENGTH, 16'd2);
        settings_used++;
        f = '{8'hFF, 8'hFF};
        send_frame(f);
        settle();

        write_reg(CFG_EXPECTED_LENGTH, 16'd4);
        write_reg(CFG_COMMAND_KIND, 16'(CMD_READ_MULTI));
        settings_used++;
        send_frame(make_frame(4, 1'b1));
        settle();

        write_reg(CFG_COMMAND_KIND, 16'(CMD_OTHER));
        settings_used++;
        send_frame(make_frame(4, 1'b1));
        settle();

        write_reg(CFG_EXPECTED_LENGTH, 16'd3);
        write_reg(CFG_COMMAND_KIND, 16'(CMD_WRITE_SINGLE));
        write_reg(CFG_REQUEST_CRC, 16'hFFFF);
        settings_used++;
        send_frame(make_frame(3, 1'b1));
        settle();

        while (bytes_sent < BYTE_BUDGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                e = $urandom_range(3, 12);
            else if (r < 70)
                e = $urandom_range(1, 2);
            else if (r < 78)
                e = $urandom_range(13, 40);
            else if (r < 82)
                e = 0;
            else if (r < 84 && full_phases < 2)
            begin
                e = FRAME_LIMIT;
                full_phases++;
            end
            else if (r < 90)
                e = $urandom_range(FRAME_LIMIT + 1, (1 << EXP_LEN_W) - 1);
            else
                e = $urandom_range(2, 8);
            write_reg(CFG_EXPECTED_LENGTH,
                      {7'($urandom()), 9'(e)});
            write_reg(CFG_COMMAND_KIND,
                      {14'($urandom()), 2'($urandom_range(0, 3))});
            r = $urandom_range(0, 9);
            write_reg(CFG_REQUEST_CRC,
                      (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom()));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNUSED_INDEX, 16'($urandom()));
            settings_used++;
            steady   = ($urandom_range(0, 4) == 0);
            n_frames = (e == FRAME_LIMIT) ? $urandom_range(1, 2) : $urandom_range(3, 8);

            for (int k = 0; k < n_frames; k++)
            begin
                r = $urandom_range(0, 99);
                if (r >= 98 && long_frames < 2)
                begin
                    long_frames++;
                    len = $urandom_range(FRAME_LIMIT + 1, FRAME_LIMIT + 6);
                    f = make_frame(len, $urandom_range(0, 1));
                end
                else if (e >= 1 && e <= FRAME_LIMIT && r < 70)
                    f = make_frame(e, $urandom_range(0, 9) != 0);
                else if (e >= 1 && e <= FRAME_LIMIT && r < 85)
                begin
                    len = e + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 3);
                    if (len < 1)
                        len = 1;
                    f = make_frame(len, $urandom_range(0, 1));
                end
                else
                    f = make_frame($urandom_range(1, 12), $urandom_range(0, 1));
                send_frame(f);
            end
            settle();
        end

        settle();
        $display("Checked %0d verdicts from %0d frames (%0d bytes) over %0d register settings.",
                 sb.checked, frames_sent, bytes_sent, settings_used);
        $display("Verdicts: length error %0d, write echo %0d, multi write %0d, read %0d, crc error %0d.",
                 sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3], sb.seen[4]);
        if (sb.mismatches == 0 && sb.expected_verdicts.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches, %0d verdicts outstanding.",
                     sb.mismatches, sb.expected_verdicts.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
